// ===== rtl/core/dpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for the depth pixel back-projection unit
// Field widths, register indexes, reset values and the control interface
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Field widths
  localparam int DEPTH_W    = 16;
  localparam int INV_W      = 24;
  localparam int CENTRE_W   = 18;
  localparam int SIZE_W     = 13;
  localparam int COORD_W    = 28;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Q.30 product to Q.8 result
  localparam int FRAC_SHIFT = 22;
  // Centre is Q.6, so positions are scaled by 64
  localparam int CENTRE_FRAC = 6;

  localparam int MAX_DIMENSION_DEF = 4096;

  // Saturation limits of the 28-bit signed coordinate
  localparam logic [COORD_W-1:0] COORD_POS_SAT = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_NEG_SAT = {1'b1, {(COORD_W-1){1'b0}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_U  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_V  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_U     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_V     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  // Register reset values
  localparam logic [INV_W-1:0]    RST_INV_FOCAL_U  = 24'd28694;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL_V  = 24'd28645;
  localparam logic [CENTRE_W-1:0] RST_CENTRE_U     = 18'd20388;
  localparam logic [CENTRE_W-1:0] RST_CENTRE_V     = 18'd16393;
  localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = 13'd480;

  // Camera and frame configuration
  typedef struct packed {
    logic [INV_W-1:0]    inv_focal_u;
    logic [INV_W-1:0]    inv_focal_v;
    logic [CENTRE_W-1:0] centre_u;
    logic [CENTRE_W-1:0] centre_v;
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
  } dpb_cfg_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;       // capture pixel, advance position
    logic mul_en;     // load product register
    logic mul_step_b; // 0: magnitude * depth, 1: partial * reciprocal
    logic mul_y;      // multiplier works on the row axis
    logic rnd_en;     // round and saturate the product
    logic rnd_y;      // rounder result goes to the row axis
    logic out_load;   // move finished point to the output register
  } dpb_cmd_t;

  // Datapath status to the sequencer
  typedef struct packed {
    logic out_free;   // output register empty or being taken this cycle
  } dpb_status_t;

endpackage

// ===== rtl/core/dpb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_ctrl: sequencer for the back-projection datapath
// Walks one pixel through the shared multiplier and rounder, column axis
// first, then row axis, then hands the point to the output register.
// ----------------------------------------------------------------------------
module dpb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  dpb_pkg::dpb_status_t status,
  output dpb_pkg::dpb_cmd_t    cmd
);
  import dpb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_XA    = 3'd1;
  localparam logic [2:0] S_XB    = 3'd2;
  localparam logic [2:0] S_XR_YA = 3'd3;
  localparam logic [2:0] S_YB    = 3'd4;
  localparam logic [2:0] S_YR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign pixel_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = pixel_valid;
        if (pixel_valid) state_next = S_XA;
      end
      S_XA: begin
        cmd.mul_en = 1'b1;
        state_next = S_XB;
      end
      S_XB: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_step_b = 1'b1;
        state_next     = S_XR_YA;
      end
      S_XR_YA: begin
        // round column result while the row axis starts in the multiplier
        cmd.rnd_en = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_y  = 1'b1;
        state_next = S_YB;
      end
      S_YB: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_step_b = 1'b1;
        cmd.mul_y      = 1'b1;
        state_next     = S_YR;
      end
      S_YR: begin
        cmd.rnd_en = 1'b1;
        cmd.rnd_y  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/dpb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_datapath: position counters, shared multiplier, rounder, output register
// Computes floor(((pos << 6) - centre) * z * inv / 2^22), saturated to 28 bits,
// for the column and row axes using one registered multiplier.
// ----------------------------------------------------------------------------
module dpb_datapath #(
  parameter int MAX_DIMENSION = dpb_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dpb_pkg::dpb_cfg_t                   cfg,
  input  dpb_pkg::dpb_cmd_t                   cmd,
  output dpb_pkg::dpb_status_t                status,
  input  logic [dpb_pkg::DEPTH_W-1:0]         depth_mm,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                point_valid,
  output logic signed [dpb_pkg::COORD_W-1:0]  x_mm_q8,
  output logic signed [dpb_pkg::COORD_W-1:0]  y_mm_q8,
  output logic [dpb_pkg::DEPTH_W-1:0]         z_mm,
  output logic                                last_of_frame
);
  import dpb_pkg::*;

  localparam int POS_W  = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
  localparam int CMP_W  = (POS_W + 1 > SIZE_W) ? POS_W + 1 : SIZE_W;
  localparam int MAG_W  = (POS_W + CENTRE_FRAC > CENTRE_W) ? POS_W + CENTRE_FRAC : CENTRE_W;
  localparam int P1_W   = MAG_W + DEPTH_W;
  localparam int PROD_W = P1_W + INV_W;
  localparam int Q_W    = PROD_W - FRAC_SHIFT + 1;
  localparam logic [CMP_W-1:0] MAX_SIZE = CMP_W'(MAX_DIMENSION);
  localparam logic [CMP_W-1:0] ONE_SIZE = CMP_W'(1);
  localparam logic [Q_W-1:0]   Q_POS_LIM = Q_W'(COORD_POS_SAT);
  localparam logic [Q_W-1:0]   Q_NEG_LIM = Q_W'(COORD_NEG_SAT);

  // Position state
  logic [POS_W-1:0] column_position;
  logic [POS_W-1:0] row_position;

  // Per-pixel working registers
  logic [DEPTH_W-1:0] z_r;
  logic               last_r;
  logic [MAG_W-1:0]   mag_u;
  logic [MAG_W-1:0]   mag_v;
  logic               neg_u;
  logic               neg_v;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] x_res;
  logic [COORD_W-1:0] y_res;

  // Effective frame size: zero counts as one, clamp at the maximum
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] height_ext;
  logic [CMP_W-1:0] eff_w;
  logic [CMP_W-1:0] eff_h;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  logic             last_col;
  logic             last_row;

  assign width_ext  = CMP_W'(cfg.frame_width);
  assign height_ext = CMP_W'(cfg.frame_height);
  assign eff_w = (width_ext == '0) ? ONE_SIZE : ((width_ext > MAX_SIZE) ? MAX_SIZE : width_ext);
  assign eff_h = (height_ext == '0) ? ONE_SIZE :
                 ((height_ext > MAX_SIZE) ? MAX_SIZE : height_ext);
  assign col_inc  = CMP_W'(column_position) + ONE_SIZE;
  assign row_inc  = CMP_W'(row_position) + ONE_SIZE;
  assign last_col = (col_inc >= eff_w);
  assign last_row = (row_inc >= eff_h);

  // Signed offset from the principal point, as sign and magnitude
  logic [MAG_W-1:0] pos_u;
  logic [MAG_W-1:0] pos_v;
  logic [MAG_W-1:0] cen_u;
  logic [MAG_W-1:0] cen_v;
  logic             lt_u;
  logic             lt_v;

  assign pos_u = MAG_W'({column_position, {CENTRE_FRAC{1'b0}}});
  assign pos_v = MAG_W'({row_position, {CENTRE_FRAC{1'b0}}});
  assign cen_u = MAG_W'(cfg.centre_u);
  assign cen_v = MAG_W'(cfg.centre_v);
  assign lt_u  = (pos_u < cen_u);
  assign lt_v  = (pos_v < cen_v);

  // Raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (cmd.load) begin
      if (last_col) begin
        column_position <= '0;
        row_position    <= last_row ? '0 : POS_W'(row_inc);
      end else begin
        column_position <= POS_W'(col_inc);
      end
    end
  end

  // Pixel capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r    <= depth_mm;
      last_r <= last_col && last_row;
      neg_u  <= lt_u;
      neg_v  <= lt_v;
      mag_u  <= lt_u ? (cen_u - pos_u) : (pos_u - cen_u);
      mag_v  <= lt_v ? (cen_v - pos_v) : (pos_v - cen_v);
    end
  end

  // Shared multiplier: step A magnitude * depth, step B partial * reciprocal
  logic [P1_W-1:0]   mul_a;
  logic [INV_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_out;

  assign mul_a = cmd.mul_step_b ? prod[P1_W-1:0] :
                 P1_W'(cmd.mul_y ? mag_v : mag_u);
  assign mul_b = cmd.mul_step_b ? (cmd.mul_y ? cfg.inv_focal_v : cfg.inv_focal_u) :
                 INV_W'(z_r);
  assign mul_out = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_out;
    end
  end

  // Rounder: floor to Q.8 (ceil of magnitude for negatives), then saturate.
  // Zero depth gives a zero product and so a zero coordinate.
  logic               rnd_neg;
  logic [Q_W-1:0]     q_mag;
  logic [COORD_W-1:0] rnd_out;

  assign rnd_neg = cmd.rnd_y ? neg_v : neg_u;
  assign q_mag   = Q_W'(prod[PROD_W-1:FRAC_SHIFT]) +
                   Q_W'(rnd_neg && (prod[FRAC_SHIFT-1:0] != '0));

  always_comb begin
    if (rnd_neg) begin
      rnd_out = (q_mag > Q_NEG_LIM) ? COORD_NEG_SAT : (COORD_W'(0) - q_mag[COORD_W-1:0]);
    end else begin
      rnd_out = (q_mag > Q_POS_LIM) ? COORD_POS_SAT : q_mag[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) begin
      if (cmd.rnd_y) begin
        y_res <= rnd_out;
      end else begin
        x_res <= rnd_out;
      end
    end
  end

  // Output register
  assign status.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_valid   <= (z_r != '0);
      x_mm_q8       <= x_res;
      y_mm_q8       <= y_res;
      z_mm          <= z_r;
      last_of_frame <= last_r;
    end
  end

endmodule

// ===== rtl/core/depth_pixel_backprojection_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A point is valid once its pixel has passed states XA, XB, XR_YA, YB, YR, DONE.
// A new pixel is taken only in idle, as the single shared multiplier takes two
// passes per axis plus rounding and the output handoff; DONE waits for a free
// output register, but a result waiting there does not block the next pixel.
// Reset (synchronous, active high) restores the default camera registers
// and returns the raster position to column 0, row 0.
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit: depth image to point cloud back-projection
// Raster-ordered depth pixels in, pinhole back-projected points out.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit #(
  parameter int MAX_DIMENSION = dpb_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_data,
  // pixel channel
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  logic [dpb_pkg::DEPTH_W-1:0]          depth_mm,
  // point channel
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 point_valid,
  output logic signed [dpb_pkg::COORD_W-1:0]   x_mm_q8,
  output logic signed [dpb_pkg::COORD_W-1:0]   y_mm_q8,
  output logic [dpb_pkg::DEPTH_W-1:0]          z_mm,
  output logic                                 last_of_frame
);
  import dpb_pkg::*;

  dpb_cfg_t    cfg;
  dpb_cmd_t    cmd;
  dpb_status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_focal_u  <= RST_INV_FOCAL_U;
      cfg.inv_focal_v  <= RST_INV_FOCAL_V;
      cfg.centre_u     <= RST_CENTRE_U;
      cfg.centre_v     <= RST_CENTRE_V;
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_FOCAL_U:  cfg.inv_focal_u  <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_V:  cfg.inv_focal_v  <= cfg_data[INV_W-1:0];
        REG_CENTRE_U:     cfg.centre_u     <= cfg_data[CENTRE_W-1:0];
        REG_CENTRE_V:     cfg.centre_v     <= cfg_data[CENTRE_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dpb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .status      (status),
    .cmd         (cmd)
  );

  dpb_datapath #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .depth_mm      (depth_mm),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .point_valid   (point_valid),
    .x_mm_q8       (x_mm_q8),
    .y_mm_q8       (y_mm_q8),
    .z_mm          (z_mm),
    .last_of_frame (last_of_frame)
  );

endmodule

// ===== dv/tb_depth_pixel_backprojection_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_unit: self-checking bench for depth back-projection
// Streams raster-ordered depth pixels under several camera register settings.
// Each point is compared with an in-bench pinhole back-projection model that
// tracks the raster position. The bench starts with a short table of directed
// rows and then sends random pixels, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_unit;
  import dpb_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 11;
  localparam int PHASES           = 6;
  localparam int ITEMS_PER_PHASE  = 314;
  localparam int HOLD_CYCLES      = 90;
  // Quiet stretches in a good run stay well under this limit (hold plus stalls)
  localparam int WATCHDOG_LIMIT   = 2000;
  // Idle tail run after all points have come back
  localparam int TAIL_CYCLES      = 28;

  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));

  // Indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        z;
    logic                      last;
  } point_t;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;  // write rows only
    logic [CFG_DATA_W-1:0] data;   // write rows only
    logic [DEPTH_W-1:0]    depth;  // pixel rows only
    logic                  typed;  // 1: use the point below, 0: use the model
    point_t                want;
  } row_t;

  typedef enum {SET_NOMINAL, SET_RANDOM, SET_EXTREME} camera_set_t;

  // Points that can be read off directly
  localparam point_t PT_MODEL = '0;
  localparam point_t PT_EMPTY = '{valid: 1'b0, x: '0, y: '0, z: '0, last: 1'b0};
  localparam point_t PT_EMPTY_LAST = '{valid: 1'b0, x: '0, y: '0, z: '0, last: 1'b1};
  localparam point_t PT_ORIGIN_FAR_LAST =
    '{valid: 1'b1, x: '0, y: '0, z: 16'hFFFF, last: 1'b1};
  localparam point_t PT_CORNER_SAT =
    '{valid: 1'b1, x: COORD_NEG_SAT, y: COORD_NEG_SAT, z: 16'hFFFF, last: 1'b0};

  localparam int DIRECTED_ROWS = 33;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset camera, first row of a 640x480 frame
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h0000, 1'b1, PT_EMPTY},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h0001, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hAAAA, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h5555, 1'b0, PT_MODEL},
    // zero sizes count as 1x1; shrinks the frame under the current column
    '{ROW_WRITE, REG_FRAME_WIDTH,  24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_CENTRE_U,     24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_CENTRE_V,     24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h04D2, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b1, PT_ORIGIN_FAR_LAST},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h0000, 1'b1, PT_EMPTY_LAST},
    // full-scale camera; oversize frame clamps to the maximum dimension
    '{ROW_WRITE, REG_INV_FOCAL_U,  24'hFFFFFF, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_INV_FOCAL_V,  24'hFFFFFF, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_CENTRE_U,     24'hFFFFFF, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_CENTRE_V,     24'h03FFFF, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_FRAME_WIDTH,  24'hFFFFFF, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 24'h001001, 16'h0000, 1'b0, PT_MODEL},
    // writes past the register file must not land anywhere
    '{ROW_WRITE, REG_SPARE_6,      24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_SPARE_7,      24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b1, PT_CORNER_SAT},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h0001, 1'b0, PT_MODEL},
    // centre at the origin: x climbs into positive saturation
    '{ROW_WRITE, REG_CENTRE_U,     24'h000000, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_WRITE, REG_CENTRE_V,     24'h000040, 16'h0000, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h8000, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'h7FFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL},
    '{ROW_PIXEL, REG_INV_FOCAL_U,  24'h000000, 16'hFFFF, 1'b0, PT_MODEL}
  };

  localparam camera_set_t PHASE_PLAN [PHASES] =
    '{SET_NOMINAL, SET_RANDOM, SET_EXTREME, SET_RANDOM, SET_NOMINAL, SET_EXTREME};

  // DUT ports
  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index    = REG_INV_FOCAL_U;
  logic [CFG_DATA_W-1:0]       cfg_data     = '0;
  logic                        pixel_valid  = 1'b0;
  logic                        pixel_ready;
  logic [DEPTH_W-1:0]          depth_mm     = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  logic                        point_valid;
  logic signed [COORD_W-1:0]   x_mm_q8;
  logic signed [COORD_W-1:0]   y_mm_q8;
  logic [DEPTH_W-1:0]          z_mm;
  logic                        last_of_frame;

  // Side info that travels with the pixel being offered
  logic   pix_typed  = 1'b0;
  point_t pix_expect = '0;

  // Traffic shaping; hold requests are counted by the sender, served by the receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  // Model copy of the camera registers and the raster position
  logic [INV_W-1:0]    cam_inv_u, cam_inv_v;
  logic [CENTRE_W-1:0] cam_centre_u, cam_centre_v;
  logic [SIZE_W-1:0]   cam_width, cam_height;
  int                  col_pos, row_pos;

  point_t expected_points[$];

  int mismatches    = 0;
  int pixels_in     = 0;
  int points_out    = 0;
  int frames_closed = 0;
  int empty_points  = 0;
  int sat_coords    = 0;
  int reg_writes    = 0;
  int quiet_cycles  = 0;

  depth_pixel_backprojection_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .depth_mm      (depth_mm),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .point_valid   (point_valid),
    .x_mm_q8       (x_mm_q8),
    .y_mm_q8       (y_mm_q8),
    .z_mm          (z_mm),
    .last_of_frame (last_of_frame)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Back-projection model
  // ---------------------------------------------------------------------------

  // Size 0 acts as 1, anything past the maximum acts as the maximum
  function automatic int frame_extent(input logic [SIZE_W-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return int'(size);
  endfunction

  // ((pos in Q.6) - centre) * z * inv is Q.30; floor to Q.8, then saturate
  function automatic logic [COORD_W-1:0] axis_coord(input int pos,
                                                    input logic [CENTRE_W-1:0] centre,
                                                    input logic [DEPTH_W-1:0] z,
                                                    input logic [INV_W-1:0] inv);
    longint offset, prod, q;
    offset = (longint'(pos) <<< CENTRE_FRAC) - longint'(centre);
    prod   = offset * longint'(z) * longint'(inv);
    q      = prod >>> FRAC_SHIFT;
    if (q > COORD_MAX) q = COORD_MAX;
    else if (q < COORD_MIN) q = COORD_MIN;
    return q[COORD_W-1:0];
  endfunction

  // Point for one depth sample, then step the raster position
  function automatic point_t backproject_pixel(input logic [DEPTH_W-1:0] depth);
    int     w, h;
    bit     end_col, end_row;
    point_t pt;
    w       = frame_extent(cam_width);
    h       = frame_extent(cam_height);
    end_col = (col_pos + 1 >= w);
    end_row = (row_pos + 1 >= h);
    pt      = '0;
    if (depth != 0) begin
      pt.valid = 1'b1;
      pt.x     = axis_coord(col_pos, cam_centre_u, depth, cam_inv_u);
      pt.y     = axis_coord(row_pos, cam_centre_v, depth, cam_inv_v);
      pt.z     = depth;
    end
    pt.last = end_col && end_row;
    if (end_col) begin
      col_pos = 0;
      row_pos = end_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return pt;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH point %0d %s: got %0d expected %0d", points_out, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on pixel transfer, check points
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t got, want;
    if (rst) begin
      cam_inv_u    = RST_INV_FOCAL_U;
      cam_inv_v    = RST_INV_FOCAL_V;
      cam_centre_u = RST_CENTRE_U;
      cam_centre_v = RST_CENTRE_V;
      cam_width    = RST_FRAME_WIDTH;
      cam_height   = RST_FRAME_HEIGHT;
      col_pos      = 0;
      row_pos      = 0;
    end else begin
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          REG_INV_FOCAL_U:  cam_inv_u    = cfg_data[INV_W-1:0];
          REG_INV_FOCAL_V:  cam_inv_v    = cfg_data[INV_W-1:0];
          REG_CENTRE_U:     cam_centre_u = cfg_data[CENTRE_W-1:0];
          REG_CENTRE_V:     cam_centre_v = cfg_data[CENTRE_W-1:0];
          REG_FRAME_WIDTH:  cam_width    = cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT: cam_height   = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end

      if (result_valid && result_ready) begin
        got.valid = point_valid;
        got.x     = x_mm_q8;
        got.y     = y_mm_q8;
        got.z     = z_mm;
        got.last  = last_of_frame;
        if (expected_points.size() == 0) begin
          report_mismatch("point with no pixel pending", 0, 0);
        end else begin
          want = expected_points.pop_front();
          if (got.valid !== want.valid)
            report_mismatch("point_valid", longint'(got.valid), longint'(want.valid));
          if (got.x !== want.x) report_mismatch("x_mm_q8", got.x, want.x);
          if (got.y !== want.y) report_mismatch("y_mm_q8", got.y, want.y);
          if (got.z !== want.z) report_mismatch("z_mm", longint'(got.z), longint'(want.z));
          if (got.last !== want.last)
            report_mismatch("last_of_frame", longint'(got.last), longint'(want.last));
        end
        points_out++;
        if (got.last === 1'b1) frames_closed++;
        if (got.valid === 1'b0) empty_points++;
        if (got.x == COORD_POS_SAT || got.x == COORD_NEG_SAT) sat_coords++;
        if (got.y == COORD_POS_SAT || got.y == COORD_NEG_SAT) sat_coords++;
      end

      if (pixel_valid && pixel_ready) begin
        want = backproject_pixel(depth_mm);
        if (pix_typed) want = pix_expect;
        expected_points.push_back(want);
        pixels_in++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no transfer of any kind ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || cfg_we || (pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d points pending",
                 quiet_cycles, expected_points.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      hold_left    = HOLD_CYCLES;
      holds_served = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel sender
  // ---------------------------------------------------------------------------

  // Offer one pixel at a falling edge; returns at the falling edge after transfer
  task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic typed,
                            input point_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    depth_mm    <= depth;
    pix_typed   <= typed;
    pix_expect  <= want;
    do @(posedge clk); while (!pixel_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every point has come back
  task automatic settle_points();
    pixel_valid <= 1'b0;
    do @(negedge clk); while (expected_points.size() != 0);
  endtask

  // Caller lowers cfg_we after the last write of a batch
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 30) return DEPTH_W'($urandom_range(1, 255));
    return DEPTH_W'($urandom);
  endfunction

  function automatic logic [SIZE_W-1:0] extreme_size();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return SIZE_W'(1);
      2: return SIZE_W'(2);
      3: return SIZE_W'(MAX_DIMENSION_DEF);
      default: return SIZE_W'($urandom_range(MAX_DIMENSION_DEF + 1, 8191));
    endcase
  endfunction

  // Write all six registers; unused upper data bits carry noise
  task automatic configure_camera(input camera_set_t kind);
    logic [INV_W-1:0]    inv_u, inv_v;
    logic [CENTRE_W-1:0] cu, cv;
    logic [SIZE_W-1:0]   w, h;
    case (kind)
      SET_NOMINAL: begin
        inv_u = RST_INV_FOCAL_U;
        inv_v = RST_INV_FOCAL_V;
        w     = SIZE_W'($urandom_range(1, 12));
        h     = SIZE_W'($urandom_range(1, 6));
        cu    = CENTRE_W'($urandom_range(0, 64 * int'(w)));
        cv    = CENTRE_W'($urandom_range(0, 64 * int'(h)));
      end
      SET_RANDOM: begin
        inv_u = INV_W'($urandom_range(1, 24'hFFFFFF));
        inv_v = INV_W'($urandom_range(1, 24'hFFFFFF));
        w     = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(13, 64))
                                            : SIZE_W'($urandom_range(1, 12));
        h     = SIZE_W'($urandom_range(1, 8));
        cu    = $urandom_range(0, 1) ? CENTRE_W'($urandom)
                                     : CENTRE_W'($urandom_range(0, 64 * (int'(w) + 2)));
        cv    = $urandom_range(0, 1) ? CENTRE_W'($urandom)
                                     : CENTRE_W'($urandom_range(0, 64 * (int'(h) + 2)));
      end
      default: begin
        inv_u = $urandom_range(0, 1) ? INV_W'(1) : '1;
        inv_v = $urandom_range(0, 1) ? INV_W'(1) : '1;
        cu    = $urandom_range(0, 1) ? '0 : '1;
        cv    = $urandom_range(0, 1) ? '0 : '1;
        w     = extreme_size();
        h     = extreme_size();
      end
    endcase
    write_register(REG_INV_FOCAL_U, inv_u);
    write_register(REG_INV_FOCAL_V, inv_v);
    write_register(REG_CENTRE_U, {6'($urandom), cu});
    write_register(REG_CENTRE_V, {6'($urandom), cv});
    write_register(REG_FRAME_WIDTH, {11'($urandom), w});
    write_register(REG_FRAME_HEIGHT, {11'($urandom), h});
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int   r, phase, n;
    bit   in_flight;
    row_t cur;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed table; registers change only with nothing in flight
    send_idle_pct = 16;
    recv_idle_pct = 53;
    in_flight     = 1'b0;
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      cur = DIRECTED[r];
      if (cur.kind == ROW_WRITE) begin
        if (in_flight) begin
          settle_points();
          in_flight = 1'b0;
        end
        write_register(cur.index, cur.data);
      end else begin
        cfg_we <= 1'b0;
        send_pixel(cur.depth, cur.typed, cur.want);
        in_flight = 1'b1;
      end
    end
    settle_points();

    // Random phases: sender-light, receiver-light, then no idling
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 53;
      end else if (phase < 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure_camera(PHASE_PLAN[phase]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // receiver backs off while pixels keep coming, so the input stalls
        if (phase == 0 && n == 120) hold_requests++;
        // sender stops mid-frame until the pipe is empty
        if (phase == 3 && n == 150) settle_points();
        send_pixel(pick_depth(), 1'b0, PT_MODEL);
      end
      settle_points();
    end

    recv_idle_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d pixels and %0d points over %0d register writes, %0d frame ends",
             pixels_in, points_out, reg_writes, frames_closed);
    $display("%0d empty-depth points, %0d saturated coordinates, %0d mismatches",
             empty_points, sat_coords, mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
